// ===== design/task_history_window_features_assert.svh =====
// Assertion macros for the task history window design.
`ifndef TASK_HISTORY_WINDOW_FEATURES_ASSERT_SVH
`define TASK_HISTORY_WINDOW_FEATURES_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define THWF_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define THWF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/thwf_pkg.sv =====
// Package: types and fixed field widths of the task history window block.
package thwf_pkg;

   localparam int ID_WIDTH    = 22;
   localparam int STATE_WIDTH = 3;
   localparam int CPU_WIDTH   = 9;
   localparam int Q16_WIDTH   = 17;
   localparam int FRAC_BITS   = 16;
   localparam int STEP_WIDTH  = 5;

   localparam logic [Q16_WIDTH-1:0]  Q16_ONE       = 17'h10000;
   localparam logic [STEP_WIDTH-1:0] DIV_LAST_STEP = 5'd16;
   localparam logic [STATE_WIDTH-1:0] STATE_RUNNING = 3'd0;

   typedef enum logic [4:0] {
      ST_IDLE     = 5'b00001,
      ST_SCAN     = 5'b00010,
      ST_DIV_FRAC = 5'b00100,
      ST_DIV_AFF  = 5'b01000,
      ST_FINISH   = 5'b10000
   } seq_state_type;

   typedef struct packed {
      logic                 running;
      logic [CPU_WIDTH-1:0] cpu;
   } window_entry_type;

endpackage

// ===== design/thwf_if.sv =====
// Interfaces: sample request channel and feature result channel.
interface thwf_req_if;
   logic                              valid;
   logic                              ready;
   logic [thwf_pkg::ID_WIDTH-1:0]     process_id;
   logic [thwf_pkg::STATE_WIDTH-1:0]  run_state;
   logic signed [thwf_pkg::CPU_WIDTH-1:0] cpu_number;

   modport source (output valid, output process_id, output run_state, output cpu_number,
                   input ready);
   modport sink (input valid, input process_id, input run_state, input cpu_number,
                 output ready);
endinterface

interface thwf_rsp_if #(parameter int COUNT_WIDTH = 5);
   logic                            valid;
   logic                            ready;
   logic [thwf_pkg::Q16_WIDTH-1:0]  running_fraction;
   logic [thwf_pkg::Q16_WIDTH-1:0]  affinity_score;
   logic [COUNT_WIDTH-1:0]          samples_held;

   modport source (output valid, output running_fraction, output affinity_score,
                   output samples_held, input ready);
   modport sink (input valid, input running_fraction, input affinity_score,
                 input samples_held, output ready);
endinterface

// ===== design/task_history_window_features.sv =====
// After a request transfer the block scans the n samples held (1..depth), then divides.
// The window scan reads through the registered memory read port, and the shared
// restoring divider is run twice per request (once if no CPU).
// No new sample is taken before the block is through with the last one: req ready only while idle.
// Reset (synchronous, active high) clears tracked id, ring position, count and control;
// window memory contents are not cleared, only slots below the count are ever used.
`include "task_history_window_features_assert.svh"

module task_history_window_features #(
   parameter int WINDOW_DEPTH = 16,
   parameter int CPU_LIMIT    = 256
) (
   input  logic             clock,
   input  logic             reset,
   thwf_req_if.sink         req_bus,
   thwf_rsp_if.source       rsp_bus
);

   localparam int CountWidth = $clog2(WINDOW_DEPTH + 1);
   localparam int AddrWidth  = $clog2(WINDOW_DEPTH);
   localparam int SeenWidth  = $clog2(CPU_LIMIT);
   localparam logic [CountWidth-1:0] DepthCount = CountWidth'(WINDOW_DEPTH);
   localparam logic [AddrWidth-1:0]  LastSlot   = AddrWidth'(WINDOW_DEPTH - 1);
   localparam logic [thwf_pkg::CPU_WIDTH-1:0] CpuLimitCode =
      thwf_pkg::CPU_WIDTH'(CPU_LIMIT);

   thwf_pkg::seq_state_type state_ff, state_in;

   logic [thwf_pkg::ID_WIDTH-1:0] tracked_id_ff, tracked_id_in;
   logic [AddrWidth-1:0]          write_slot_ff, write_slot_in;
   logic [CountWidth-1:0]         count_ff, count_in;
   logic [CountWidth-1:0]         idx_ff, idx_in;
   logic                          pend_ff, pend_in;
   // distinct CPUs found so far in this scan; the list never outgrows the window
   logic [SeenWidth-1:0]          distinct_ff [WINDOW_DEPTH];
   logic [SeenWidth-1:0]          distinct_in [WINDOW_DEPTH];
   logic [CountWidth-1:0]         running_ff, running_in;
   logic [CountWidth-1:0]         unique_ff, unique_in;
   logic [CountWidth-1:0]         rem_ff, rem_in;
   logic [thwf_pkg::Q16_WIDTH-1:0] quot_ff, quot_in;
   logic [thwf_pkg::STEP_WIDTH-1:0] step_ff, step_in;
   logic [thwf_pkg::Q16_WIDTH-1:0] frac_ff, frac_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [thwf_pkg::Q16_WIDTH-1:0] rsp_frac_ff, rsp_frac_in;
   logic [thwf_pkg::Q16_WIDTH-1:0] rsp_aff_ff, rsp_aff_in;
   logic [CountWidth-1:0]          rsp_held_ff, rsp_held_in;

   // window memory: one write port at accept, one registered read port for the scan
   thwf_pkg::window_entry_type window_mem [WINDOW_DEPTH];
   thwf_pkg::window_entry_type rd_data_ff;
   thwf_pkg::window_entry_type wr_entry;

   logic                  req_xfer;
   logic                  id_change;
   logic [AddrWidth-1:0]  wr_slot;
   logic                  cpu_ok;
   logic                  cpu_dup;
   logic [CountWidth:0]   trial;
   logic [CountWidth:0]   divisor_ext;
   logic                  trial_ge;
   logic [CountWidth-1:0] rem_next;
   logic [thwf_pkg::Q16_WIDTH-1:0] quot_next;

   assign req_bus.ready = (state_ff == thwf_pkg::ST_IDLE);
   assign req_xfer      = req_bus.valid && req_bus.ready;
   assign id_change     = (req_bus.process_id != tracked_id_ff);
   assign wr_slot       = id_change ? '0 : write_slot_ff;

   assign wr_entry.running = (req_bus.run_state == thwf_pkg::STATE_RUNNING);
   assign wr_entry.cpu     = req_bus.cpu_number;

   // negative codes have the top bit set, so one unsigned compare covers both cases
   assign cpu_ok = (rd_data_ff.cpu < CpuLimitCode);

   always_comb begin
      cpu_dup = 1'b0;
      for (int k = 0; k < WINDOW_DEPTH; k++) begin
         if (CountWidth'(k) < unique_ff &&
             distinct_ff[k] == rd_data_ff.cpu[SeenWidth-1:0]) begin
            cpu_dup = 1'b1;
         end
      end
   end

   // shared restoring divider step
   assign divisor_ext = {1'b0, (state_ff == thwf_pkg::ST_DIV_AFF) ? unique_ff : count_ff};
   assign trial       = {rem_ff, quot_ff[thwf_pkg::Q16_WIDTH-1]};
   assign trial_ge    = (trial >= divisor_ext);
   assign rem_next    = trial_ge ? CountWidth'(trial - divisor_ext) : trial[CountWidth-1:0];
   assign quot_next   = {quot_ff[thwf_pkg::Q16_WIDTH-2:0], trial_ge};

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         window_mem[wr_slot] <= wr_entry;
      end
      rd_data_ff <= window_mem[idx_ff[AddrWidth-1:0]];
   end

   always_comb begin
      state_in      = state_ff;
      tracked_id_in = tracked_id_ff;
      write_slot_in = write_slot_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      pend_in       = pend_ff;
      distinct_in   = distinct_ff;
      running_in    = running_ff;
      unique_in     = unique_ff;
      rem_in        = rem_ff;
      quot_in       = quot_ff;
      step_in       = step_ff;
      frac_in       = frac_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_frac_in   = rsp_frac_ff;
      rsp_aff_in    = rsp_aff_ff;
      rsp_held_in   = rsp_held_ff;

      case (state_ff)
         thwf_pkg::ST_IDLE: begin
            if (req_xfer) begin
               tracked_id_in = req_bus.process_id;
               write_slot_in = (wr_slot == LastSlot) ? '0 : wr_slot + 1'b1;
               if (id_change) begin
                  count_in = CountWidth'(1);
               end else if (count_ff < DepthCount) begin
                  count_in = count_ff + 1'b1;
               end
               idx_in     = '0;
               pend_in    = 1'b0;
               running_in = '0;
               unique_in  = '0;
               state_in   = thwf_pkg::ST_SCAN;
            end
         end
         thwf_pkg::ST_SCAN: begin
            if (idx_ff < count_ff) begin
               idx_in  = idx_ff + 1'b1;
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               if (rd_data_ff.running) begin
                  running_in = running_ff + 1'b1;
               end
               if (cpu_ok && !cpu_dup) begin
                  distinct_in[unique_ff[AddrWidth-1:0]] = rd_data_ff.cpu[SeenWidth-1:0];
                  unique_in = unique_ff + 1'b1;
               end
            end
            if (idx_ff == count_ff && !pend_ff) begin
               // numerator running << 16: high part preloads the remainder
               rem_in   = {1'b0, running_ff[CountWidth-1:1]};
               quot_in  = {running_ff[0], {thwf_pkg::FRAC_BITS{1'b0}}};
               step_in  = '0;
               state_in = thwf_pkg::ST_DIV_FRAC;
            end
         end
         thwf_pkg::ST_DIV_FRAC: begin
            rem_in  = rem_next;
            quot_in = quot_next;
            step_in = step_ff + 1'b1;
            if (step_ff == thwf_pkg::DIV_LAST_STEP) begin
               frac_in = quot_next;
               step_in = '0;
               rem_in  = '0;
               quot_in = thwf_pkg::Q16_ONE;
               // no usable CPU: affinity stays at one
               state_in = (unique_ff == '0) ? thwf_pkg::ST_FINISH : thwf_pkg::ST_DIV_AFF;
            end
         end
         thwf_pkg::ST_DIV_AFF: begin
            rem_in  = rem_next;
            quot_in = quot_next;
            step_in = step_ff + 1'b1;
            if (step_ff == thwf_pkg::DIV_LAST_STEP) begin
               step_in  = '0;
               state_in = thwf_pkg::ST_FINISH;
            end
         end
         thwf_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_frac_in  = frac_ff;
               rsp_aff_in   = quot_ff;
               rsp_held_in  = count_ff;
               state_in     = thwf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = thwf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= thwf_pkg::ST_IDLE;
         tracked_id_ff <= '0;
         write_slot_ff <= '0;
         count_ff      <= '0;
         idx_ff        <= '0;
         pend_ff       <= 1'b0;
         step_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         tracked_id_ff <= tracked_id_in;
         write_slot_ff <= write_slot_in;
         count_ff      <= count_in;
         idx_ff        <= idx_in;
         pend_ff       <= pend_in;
         step_ff       <= step_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      distinct_ff <= distinct_in;
      running_ff  <= running_in;
      unique_ff   <= unique_in;
      rem_ff      <= rem_in;
      quot_ff     <= quot_in;
      frac_ff     <= frac_in;
      rsp_frac_ff <= rsp_frac_in;
      rsp_aff_ff  <= rsp_aff_in;
      rsp_held_ff <= rsp_held_in;
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.running_fraction = rsp_frac_ff;
   assign rsp_bus.affinity_score   = rsp_aff_ff;
   assign rsp_bus.samples_held     = rsp_held_ff;

   `THWF_ASSERT_NEXT(a_accept_starts_scan, clock, reset, req_xfer,
      state_ff == thwf_pkg::ST_SCAN && count_ff != '0, "accept did not start a scan")
   `THWF_ASSERT_IMP(a_scan_index_bound, clock, reset, state_ff == thwf_pkg::ST_SCAN,
      idx_ff <= count_ff && count_ff <= DepthCount, "scan index past window count")
   `THWF_ASSERT_IMP(a_div_bounds, clock, reset,
      state_ff == thwf_pkg::ST_DIV_FRAC || state_ff == thwf_pkg::ST_DIV_AFF,
      rem_ff < divisor_ext[CountWidth-1:0] && running_ff <= count_ff,
      "divider remainder not below divisor")
   `THWF_ASSERT_IMP(a_result_range, clock, reset, rsp_valid_ff,
      rsp_frac_ff <= thwf_pkg::Q16_ONE && rsp_aff_ff <= thwf_pkg::Q16_ONE &&
      rsp_held_ff != '0, "result out of range")

endmodule
